>>> rtl/hdlc_deframer_crc_check_defines.svh
// Assertion helpers used by the result buffer module.
// Both expect the clock aclk and the active-low reset aresetn in scope.
`ifndef HDLC_DEFRAMER_CRC_CHECK_DEFINES_SVH
`define HDLC_DEFRAMER_CRC_CHECK_DEFINES_SVH

// Same-cycle implication.
`define HDLCDF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define HDLCDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/hdlcdf_pkg.sv
package hdlcdf_pkg;

    // Line constants
    localparam logic [7:0]  FlagByte    = 8'h7E;
    localparam logic [15:0] CrcInit     = 16'hFFFF;
    localparam logic [15:0] CrcXorOut   = 16'hFFFF;
    localparam logic [15:0] CrcPoly     = 16'h1021;

    localparam int MaxFrameBytesDefault = 4096;
    localparam int LenW        = 13;
    localparam int DataW       = 8;
    localparam int MaxResults  = 3;
    localparam int ResCntW     = $clog2(MaxResults + 1);

    // Result kinds
    localparam logic KindData   = 1'b0;
    localparam logic KindStatus = 1'b1;

    typedef enum logic [2:0] {
        StOk       = 3'd0,
        StCrcErr   = 3'd1,
        StTooShort = 3'd2,
        StAbort    = 3'd3,
        StNoEnd    = 3'd4
    } frame_status_t;

    typedef struct packed {
        logic              kind;
        logic [DataW-1:0]  data;
        frame_status_t     status;
        logic [LenW-1:0]   length;
        logic              last;
    } result_t;

    // All results caused by one input item
    typedef struct packed {
        logic [ResCntW-1:0]             cnt;
        result_t [MaxResults-1:0]       res;
    } bundle_t;

    // Bit reversal by swapping adjacent bits, nibbles' halves, then nibbles
    function automatic logic [7:0] rev8(input logic [7:0] b);
        logic [7:0] t;
        t = ((b >> 1) & 8'h55) | ((b & 8'h55) << 1);
        t = ((t >> 2) & 8'h33) | ((t & 8'h33) << 2);
        t = ((t >> 4) & 8'h0F) | ((t & 8'h0F) << 4);
        return t;
    endfunction

    // CRC-16, poly 0x1021, one byte MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                             input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/hdlcdf_result_buf.sv
`include "hdlc_deframer_crc_check_defines.svh"

// Holds the results of one item and hands them out one per cycle while m_ready is high.
module hdlcdf_result_buf
    import hdlcdf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  bundle_t bundle_in,
    output logic    can_load,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t head
);

    result_t [MaxResults-1:0] res_reg, res_next;
    logic [ResCntW-1:0]       cnt_reg, cnt_next;
    logic                     pop;

    assign m_valid  = (cnt_reg != '0);
    assign pop      = m_valid && m_ready;
    assign can_load = (cnt_reg == '0) || ((cnt_reg == ResCntW'(1)) && m_ready);
    assign head     = res_reg[0];

    // Load a new bundle or shift the head out
    always_comb begin
        res_next = res_reg;
        cnt_next = cnt_reg;
        if (load) begin
            res_next = bundle_in.res;
            cnt_next = bundle_in.cnt;
        end else if (pop) begin
            for (int i = 0; i < MaxResults - 1; i++) begin
                res_next[i] = res_reg[i+1];
            end
            cnt_next = cnt_reg - ResCntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    `HDLCDF_ASSERT_NOW(a_load_when_free, load, can_load, "bundle loaded over pending results")
    `HDLCDF_ASSERT_NOW(a_last_on_final, cnt_reg == ResCntW'(1), res_reg[0].last,
        "final result of an item lacks last")
    `HDLCDF_ASSERT_NOW(a_no_early_last, cnt_reg > ResCntW'(1), !res_reg[0].last,
        "last set before the final result")
    `HDLCDF_ASSERT_NEXT(a_pop_counts_down, pop && !load,
        cnt_reg == $past(cnt_reg) - ResCntW'(1), "pending count did not drop on pop")

endmodule

>>> rtl/hdlc_deframer_crc_check.sv
// HDLC receiver: flag hunt, zero destuffing, abort detection, two-byte
// delay line and CRC-16 (0x1021, init and xor-out 0xFFFF) check.
// Input channel s_*: one encoded line byte per item, MSB first; s_tlast
// marks the last byte of a stream and closes an open frame as no end flag.
// Result channel m_*: m_tuser 0 = data byte (bit-reversed in m_tdata[7:0]),
// 1 = frame status (m_tdata[10:8] status, m_tdata[23:11] length). m_tlast
// marks the final result caused by one input item.
// All eight bits of an item are processed in the accept cycle; its results
// appear on m_* the next cycle. An item causes zero to three results; one
// result leaves per cycle while m_tready is high, so an item is taken every
// cycle while items cause at most one result each, and an item with more
// results holds the input until all but its last result are taken. The
// next item is accepted in the cycle its predecessor's last result is taken.
// Reset (aresetn low, synchronous) empties the result buffer and returns to
// flag hunting. When m_tready is low, pending results hold and s_tready
// drops as soon as the buffer cannot take another item.
module hdlc_deframer_crc_check
    import hdlcdf_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MaxFrameBytesDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,    // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] out_data, [10:8] frame_status, [23:11] frame_length
    output logic [0:0]  m_tuser,    // [0] out_kind
    output logic        m_tlast     // last_of_item
);

    localparam int CntW = ($clog2(MAX_FRAME_BYTES + 1) > LenW) ?
                          $clog2(MAX_FRAME_BYTES + 1) : LenW;

    logic [7:0]      window_reg, window_next;
    logic            in_frame_reg, in_frame_next;
    logic [2:0]      ones_reg, ones_next;
    logic [2:0]      bip_reg, bip_next;
    logic [7:0]      partial_reg, partial_next;
    logic [7:0]      held0_reg, held0_next;
    logic [7:0]      held1_reg, held1_next;
    logic [1:0]      hcnt_reg, hcnt_next;
    logic [15:0]     crc_reg, crc_next;
    logic [CntW-1:0] count_reg, count_next;

    logic            accept;
    logic            can_load;
    logic [15:0]     crc_rel;
    bundle_t         bundle;
    result_t         head;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = can_load;

    // CRC after releasing the oldest held byte; at most one release per item
    assign crc_rel = crc_byte(crc_reg, held0_reg);

    // Eight bit steps of one item
    always_comb begin
        logic            b;
        logic            emit_en;
        logic            emit_kind;
        logic [7:0]      emit_data;
        frame_status_t   emit_st;
        logic [ResCntW-1:0] n;

        window_next   = window_reg;
        in_frame_next = in_frame_reg;
        ones_next     = ones_reg;
        bip_next      = bip_reg;
        partial_next  = partial_reg;
        held0_next    = held0_reg;
        held1_next    = held1_reg;
        hcnt_next     = hcnt_reg;
        crc_next      = crc_reg;
        count_next    = count_reg;
        bundle        = '0;
        n             = '0;

        for (int k = 7; k >= 0; k--) begin
            b         = s_tdata[k];
            emit_en   = 1'b0;
            emit_kind = KindData;
            emit_data = '0;
            emit_st   = StOk;
            window_next = {window_next[6:0], b};

            if (!in_frame_next) begin
                // hunting: opening flag clears frame state
                if (window_next == FlagByte) begin
                    in_frame_next = 1'b1;
                    ones_next     = '0;
                    bip_next      = '0;
                    partial_next  = '0;
                    hcnt_next     = '0;
                    crc_next      = CrcInit;
                    count_next    = '0;
                end
            end else if (window_next == FlagByte) begin
                // closing flag
                emit_en   = 1'b1;
                emit_kind = KindStatus;
                if (hcnt_next != 2'd2) begin
                    emit_st = StTooShort;
                end else if ((crc_next ^ CrcXorOut) == {held0_next, held1_next}) begin
                    emit_st = StOk;
                end else begin
                    emit_st = StCrcErr;
                end
                in_frame_next = 1'b0;
            end else if (b && (ones_next == 3'd6)) begin
                // seventh one: abort
                ones_next     = 3'd7;
                emit_en       = 1'b1;
                emit_kind     = KindStatus;
                emit_st       = StAbort;
                in_frame_next = 1'b0;
            end else if (!b && (ones_next == 3'd5)) begin
                // stuffed zero dropped
                ones_next = '0;
            end else begin
                ones_next    = b ? ones_next + 3'd1 : 3'd0;
                partial_next = {partial_next[6:0], b};
                if (bip_next == 3'd7) begin
                    bip_next = '0;
                    if (hcnt_next == 2'd2) begin
                        // release oldest byte through the delay line
                        crc_next   = crc_rel;
                        emit_en    = 1'b1;
                        emit_kind  = KindData;
                        emit_data  = rev8(held0_next);
                        if (count_next < CntW'(MAX_FRAME_BYTES)) begin
                            count_next = count_next + CntW'(1);
                        end
                        held0_next = held1_next;
                        held1_next = partial_next;
                    end else if (hcnt_next == 2'd0) begin
                        held0_next = partial_next;
                        hcnt_next  = 2'd1;
                    end else begin
                        held1_next = partial_next;
                        hcnt_next  = 2'd2;
                    end
                    partial_next = '0;
                end else begin
                    bip_next = bip_next + 3'd1;
                end
            end

            if (emit_en && (n != ResCntW'(MaxResults))) begin
                bundle.res[n[1:0]].kind   = emit_kind;
                bundle.res[n[1:0]].data   = emit_data;
                bundle.res[n[1:0]].status = (emit_kind == KindStatus) ? emit_st : StOk;
                bundle.res[n[1:0]].length = (emit_kind == KindStatus) ?
                                            count_next[LenW-1:0] : '0;
                n = n + ResCntW'(1);
            end
        end

        // end of stream: open frame reports missing end flag
        if (s_tlast) begin
            if (in_frame_next && (n != ResCntW'(MaxResults))) begin
                bundle.res[n[1:0]].kind   = KindStatus;
                bundle.res[n[1:0]].status = StNoEnd;
                bundle.res[n[1:0]].length = count_next[LenW-1:0];
                n = n + ResCntW'(1);
            end
            in_frame_next = 1'b0;
            window_next   = '0;
        end

        if (n != '0) begin
            bundle.res[n[1:0] - 2'd1].last = 1'b1;
        end
        bundle.cnt = n;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg   <= '0;
            in_frame_reg <= 1'b0;
            ones_reg     <= '0;
            bip_reg      <= '0;
            partial_reg  <= '0;
            hcnt_reg     <= '0;
            crc_reg      <= CrcInit;
            count_reg    <= '0;
        end else if (accept) begin
            window_reg   <= window_next;
            in_frame_reg <= in_frame_next;
            ones_reg     <= ones_next;
            bip_reg      <= bip_next;
            partial_reg  <= partial_next;
            hcnt_reg     <= hcnt_next;
            crc_reg      <= crc_next;
            count_reg    <= count_next;
        end
    end

    // Delay line bytes, read only after written
    always_ff @(posedge aclk) begin
        if (accept) begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

    hdlcdf_result_buf u_result_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept),
        .bundle_in (bundle),
        .can_load  (can_load),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .head      (head)
    );

    assign m_tdata = {head.length, head.status, head.data};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

>>> tb/sv/tb_hdlc_deframer_crc_check.sv
`timescale 1ns / 1ps

module tb_hdlc_deframer_crc_check;
    import hdlcdf_pkg::*;

    localparam int HalfPeriod   = 2;
    localparam int ResetCycles  = 6;
    localparam int SettleCycles = 8;
    localparam int CycleLimit   = 1_000_000;
    localparam int RandomItems  = 450;
    localparam int MaxReports   = 50;

    // Receiver stall patterns
    typedef enum logic [1:0] {
        RxOpen,
        RxCoin,
        RxSparse,
        RxBlock
    } rx_mode_t;

    typedef struct {
        logic [7:0] octet;
        logic       eoi;
        logic       drain_first;
    } line_item_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    hdlc_deframer_crc_check u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] in_byte
        .s_tlast  (s_tlast),    // end_of_input
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [7:0] out_data, [10:8] frame_status, [23:11] frame_length
        .m_tuser  (m_tuser),    // [0] out_kind
        .m_tlast  (m_tlast)     // last_of_item
    );

    always #(HalfPeriod) aclk = ~aclk;

    // Stimulus and expectation stores
    line_item_t  line_items[$];
    result_t     expected_results[$];
    logic        drain_next = 1'b0;
    int          queued_count = 0;

    // Line encoder state
    bit          line_bits[$];
    int          enc_ones = 0;
    logic [7:0]  frame_bytes[$];

    // Deframer shadow state
    logic [7:0]  dfr_window   = 8'h00;
    logic        dfr_in_frame = 1'b0;
    int unsigned dfr_ones     = 0;
    int unsigned dfr_nbits    = 0;
    logic [7:0]  dfr_shift    = 8'h00;
    logic [7:0]  dfr_held [2];
    int unsigned dfr_nheld    = 0;
    logic [15:0] dfr_crc      = CrcInit;
    int unsigned dfr_nbytes   = 0;

    int          failures    = 0;
    int          cycle_count = 0;
    int          rst_count   = 0;
    logic        took_item   = 1'b0;
    line_item_t  next_item;
    int          burst_left  = 0;
    int          gap_left    = 0;
    rx_mode_t    rx_mode     = RxOpen;
    int          rx_left     = 0;
    int          rx_low_run  = 0;
    int          rx_phase    = 0;
    logic        rx_ready;

    // CRC-16 one bit at a time, MSB first
    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] v);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ v[i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CrcPoly;
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] mirror8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

    function automatic result_t status_result(input frame_status_t st);
        result_t r;
        r.kind   = KindStatus;
        r.data   = '0;
        r.status = st;
        r.length = dfr_nbytes[LenW-1:0];
        r.last   = 1'b0;
        return r;
    endfunction

    // Shadow deframer: one line byte in, zero to three results out
    task automatic predict_item(input logic [7:0] octet, input logic eoi);
        result_t       batch[$];
        result_t       r;
        logic          b;
        logic [7:0]    rel;
        frame_status_t st;
        for (int k = 7; k >= 0; k--) begin
            b = octet[k];
            dfr_window = {dfr_window[6:0], b};
            if (!dfr_in_frame) begin
                // hunting: flag opens a fresh frame
                if (dfr_window == FlagByte) begin
                    dfr_in_frame = 1'b1;
                    dfr_ones     = 0;
                    dfr_nbits    = 0;
                    dfr_shift    = 8'h00;
                    dfr_nheld    = 0;
                    dfr_crc      = CrcInit;
                    dfr_nbytes   = 0;
                end
            end else if (dfr_window == FlagByte) begin
                // closing flag; unfinished byte is dropped
                if (dfr_nheld < 2) begin
                    st = StTooShort;
                end else if ((dfr_crc ^ CrcXorOut) == {dfr_held[0], dfr_held[1]}) begin
                    st = StOk;
                end else begin
                    st = StCrcErr;
                end
                batch.push_back(status_result(st));
                dfr_in_frame = 1'b0;
            end else if (b && dfr_ones == 6) begin
                // seventh one in a row
                batch.push_back(status_result(StAbort));
                dfr_in_frame = 1'b0;
            end else if (!b && dfr_ones == 5) begin
                // stuffed zero
                dfr_ones = 0;
            end else begin
                dfr_ones  = b ? dfr_ones + 1 : 0;
                dfr_shift = {dfr_shift[6:0], b};
                dfr_nbits++;
                if (dfr_nbits == 8) begin
                    // two-byte delay line ahead of the CRC
                    if (dfr_nheld >= 2) begin
                        rel      = dfr_held[0];
                        dfr_crc  = crc16_step(dfr_crc, rel);
                        r.kind   = KindData;
                        r.data   = mirror8(rel);
                        r.status = StOk;
                        r.length = '0;
                        r.last   = 1'b0;
                        batch.push_back(r);
                        if (dfr_nbytes < MaxFrameBytesDefault) begin
                            dfr_nbytes++;
                        end
                        dfr_held[0] = dfr_held[1];
                        dfr_held[1] = dfr_shift;
                    end else begin
                        dfr_held[dfr_nheld[0]] = dfr_shift;
                        dfr_nheld++;
                    end
                    dfr_shift = 8'h00;
                    dfr_nbits = 0;
                end
            end
        end
        if (eoi) begin
            if (dfr_in_frame) begin
                batch.push_back(status_result(StNoEnd));
                dfr_in_frame = 1'b0;
            end
            dfr_window = 8'h00;
        end
        if (batch.size() > 0) begin
            batch[batch.size() - 1].last = 1'b1;
        end
        foreach (batch[i]) begin
            expected_results.push_back(batch[i]);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (failures < MaxReports) begin
            $display("mismatch @%0d: %s got 0x%0h expected 0x%0h", cycle_count, what, got,
                     want);
        end
        failures++;
    endtask

    task automatic check_result();
        result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with nothing pending", 32'(m_tdata), 0);
        end else begin
            want = expected_results.pop_front();
            if (m_tuser[0] !== want.kind) begin
                report_mismatch("kind", 32'(m_tuser[0]), 32'(want.kind));
            end
            if (m_tdata[7:0] !== want.data) begin
                report_mismatch("data", 32'(m_tdata[7:0]), 32'(want.data));
            end
            if (m_tdata[10:8] !== want.status) begin
                report_mismatch("status", 32'(m_tdata[10:8]), 32'(want.status));
            end
            if (m_tdata[23:11] !== want.length) begin
                report_mismatch("length", 32'(m_tdata[23:11]), 32'(want.length));
            end
            if (m_tlast !== want.last) begin
                report_mismatch("last", 32'(m_tlast), 32'(want.last));
            end
        end
    endtask

    // Line encoder helpers
    task automatic queue_octet(input logic [7:0] v, input logic eoi);
        line_item_t it;
        it.octet       = v;
        it.eoi         = eoi;
        it.drain_first = drain_next;
        drain_next     = 1'b0;
        line_items.push_back(it);
        queued_count++;
    endtask

    task automatic put_raw(input logic [7:0] v);
        for (int i = 7; i >= 0; i--) begin
            line_bits.push_back(v[i]);
        end
    endtask

    task automatic put_flag();
        put_raw(FlagByte);
        enc_ones = 0;
    endtask

    task automatic put_data_bit(input bit b);
        line_bits.push_back(b);
        if (b) begin
            enc_ones++;
            if (enc_ones == 5) begin
                line_bits.push_back(1'b0);
                enc_ones = 0;
            end
        end else begin
            enc_ones = 0;
        end
    endtask

    task automatic put_data_byte(input logic [7:0] v);
        for (int i = 7; i >= 0; i--) begin
            put_data_bit(v[i]);
        end
    endtask

    // Flag, frame_bytes, check sequence (optionally corrupted), stray bits, flag
    task automatic put_frame(input logic [15:0] flip, input int stray_bits);
        logic [15:0] crc;
        crc = CrcInit;
        put_flag();
        foreach (frame_bytes[i]) begin
            put_data_byte(frame_bytes[i]);
            crc = crc16_step(crc, frame_bytes[i]);
        end
        crc = crc ^ CrcXorOut ^ flip;
        put_data_byte(crc[15:8]);
        put_data_byte(crc[7:0]);
        repeat (stray_bits) put_data_bit(1'($urandom_range(0, 1)));
        put_flag();
    endtask

    // Pack pending line bits into items
    task automatic flush_line(input bit pad, input logic eoi);
        logic [7:0] v;
        if (line_bits.size() == 0) begin
            repeat (8) line_bits.push_back(pad);
        end
        while (line_bits.size() % 8 != 0) line_bits.push_back(pad);
        while (line_bits.size() > 0) begin
            for (int i = 0; i < 8; i++) begin
                v = {v[6:0], line_bits.pop_front()};
            end
            queue_octet(v, eoi && line_bits.size() == 0);
        end
    endtask

    task automatic random_payload(input int len);
        frame_bytes.delete();
        repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic queue_random_frame();
        int   pick;
        int   len;
        logic eoi;
        pick = $urandom_range(0, 99);
        len  = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
        eoi  = ($urandom_range(0, 6) == 0);
        if ($urandom_range(0, 29) == 0) begin
            drain_next = 1'b1;
        end
        random_payload(len);
        if (pick < 55) begin
            put_frame(16'h0000, 0);
            flush_line(1'b1, eoi);
        end else if (pick < 65) begin
            put_frame(16'h0001 << $urandom_range(0, 15), 0);
            flush_line(1'b1, eoi);
        end else if (pick < 72) begin
            put_frame(16'h0000, $urandom_range(1, 7));
            flush_line(1'b1, eoi);
        end else if (pick < 80) begin
            // too short: at most one byte before the flag
            put_flag();
            if ($urandom_range(0, 1)) put_data_byte(8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 7)) put_data_bit(1'($urandom_range(0, 1)));
            put_flag();
            flush_line(1'b1, eoi);
        end else if (pick < 87) begin
            // abort inside a frame
            put_flag();
            repeat ($urandom_range(0, 6)) put_data_byte(8'($urandom_range(0, 255)));
            put_raw(8'hFF);
            flush_line(1'b1, eoi);
        end else if (pick < 94) begin
            // stream ends with the frame still open
            put_flag();
            repeat ($urandom_range(0, 10)) put_data_byte(8'($urandom_range(0, 255)));
            flush_line(1'b0, 1'b1);
        end else begin
            // line noise
            repeat ($urandom_range(1, 6)) queue_octet(8'($urandom_range(0, 255)), 1'b0);
            queue_octet(8'($urandom_range(0, 255)), $urandom_range(0, 2) != 0);
        end
    endtask

    // Sender: reset sequence, then bursts with gaps; items change at falling edge
    always @(negedge aclk) begin
        if (rst_count < ResetCycles) begin
            rst_count <= rst_count + 1;
            aresetn   <= 1'b0;
            s_tvalid  <= 1'b0;
        end else begin
            aresetn <= 1'b1;
            if (s_tvalid && !took_item) begin
                // hold the offered item
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (line_items.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (line_items[0].drain_first && expected_results.size() != 0) begin
                s_tvalid <= 1'b0;
            end else begin
                next_item = line_items.pop_front();
                s_tdata  <= next_item.octet;
                s_tlast  <= next_item.eoi;
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver: switches between random stall patterns and caps the length of low runs
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'(2'($urandom_range(0, 3)));
                rx_left = $urandom_range(50, 300);
            end
            rx_left--;
            rx_phase++;
            case (rx_mode)
                RxOpen:   rx_ready = 1'b1;
                RxCoin:   rx_ready = 1'($urandom_range(0, 1));
                RxSparse: rx_ready = (rx_phase % 3 == 0);
                default:  rx_ready = 1'b0;
            endcase
            if (rx_low_run >= 8) begin
                rx_ready = 1'b1;
            end
            rx_low_run = rx_ready ? 0 : rx_low_run + 1;
            m_tready <= rx_ready;
        end
    end

    // Monitor: results checked before the accepted item is predicted
    always @(posedge aclk) begin
        took_item <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                check_result();
            end
            if (s_tvalid && s_tready) begin
                predict_item(s_tdata, s_tlast);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int  rand_base;

        // hunting: extremes of the line byte, end of input with no frame open
        queue_octet(8'h00, 1'b0);
        queue_octet(8'hFF, 1'b1);
        // back-to-back flags give an empty frame
        put_flag();
        put_flag();
        flush_line(1'b1, 1'b0);
        // single byte before the closing flag
        put_flag();
        put_data_byte(8'hFF);
        put_flag();
        flush_line(1'b1, 1'b0);
        // good frame with extreme payload, sent into an empty pipe
        drain_next  = 1'b1;
        frame_bytes = {8'h00, 8'hFF};
        put_frame(16'h0000, 0);
        flush_line(1'b1, 1'b0);
        // corrupted check sequence
        frame_bytes = {8'hA5};
        put_frame(16'h0001, 0);
        flush_line(1'b1, 1'b0);
        // payload that looks like a flag, plus a partial byte dropped at the close
        frame_bytes = {FlagByte};
        put_frame(16'h0000, 5);
        flush_line(1'b1, 1'b0);
        // abort after one byte
        put_flag();
        put_data_byte(8'h3C);
        put_raw(8'hFF);
        flush_line(1'b1, 1'b0);
        // stream ends inside a frame
        put_flag();
        put_data_byte(8'h12);
        flush_line(1'b0, 1'b1);

        // random traffic
        drain_next = 1'b1;
        rand_base  = queued_count;
        while (queued_count - rand_base < RandomItems) begin
            queue_random_frame();
        end

        while (!(aresetn && line_items.size() == 0 && !s_tvalid &&
                 expected_results.size() == 0)) begin
            @(posedge aclk);
        end
        repeat (SettleCycles) @(posedge aclk);
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/hdlcdf_pkg.sv
rtl/hdlcdf_result_buf.sv
rtl/hdlc_deframer_crc_check.sv
tb/sv/tb_hdlc_deframer_crc_check.sv
